>>> hw/rtl/ple_pkg.sv
// ple_pkg: shared constants, opcodes, status codes and cell control type
// for the positional list engine. No dependencies.
package ple_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int POS_W         = 6;
  localparam int ST_W          = 2;
  localparam int CNT_OUT_W     = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  localparam logic signed [DATA_W-1:0] READ_SENTINEL = 32'sh8000_0001;

  typedef struct packed {
    logic app;
    logic ins;
    logic era;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ple_if.sv
// ple_req_if and ple_rsp_if: valid/ready channels for requests and results.
// Depends on ple_pkg for field widths.
interface ple_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [ple_pkg::OP_W-1:0]                 opcode;
  logic [ple_pkg::POS_W-1:0]                position;
  logic signed [ple_pkg::DATA_W-1:0]        value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink (input valid, opcode, position, value, output ready);
endinterface

interface ple_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ple_pkg::DATA_W-1:0]        read_value;
  logic [ple_pkg::ST_W-1:0]                 status;
  logic [ple_pkg::CNT_OUT_W-1:0]            count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink (input valid, read_value, status, count, output ready);
endinterface

>>> hw/rtl/ple_cell.sv
// ple_cell: one list entry; loads a word, takes its left neighbor on insert
// or its right neighbor on erase. Depends on ple_pkg.
module ple_cell #(
  parameter int IDX = 0,
  parameter int KW  = 7
) (
  input  logic                               clk,
  input  ple_pkg::cell_ctrl_t                ctrl,
  input  logic [KW-1:0]                      pos,
  input  logic [KW-1:0]                      cnt,
  input  logic signed [ple_pkg::DATA_W-1:0]  value,
  input  logic signed [ple_pkg::DATA_W-1:0]  left,
  input  logic signed [ple_pkg::DATA_W-1:0]  right,
  output logic signed [ple_pkg::DATA_W-1:0]  q,
  output logic signed [ple_pkg::DATA_W-1:0]  hit
);

  localparam logic [KW-1:0] MY_IDX = KW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.app) begin
      if (MY_IDX == cnt) q <= value;
    end else if (ctrl.ins) begin
      if (MY_IDX == pos) q <= value;
      else if (MY_IDX > pos) q <= left;
    end else if (ctrl.era) begin
      if (MY_IDX >= pos) q <= right;
    end
  end

  assign hit = (MY_IDX == pos) ? q : '0;

endmodule

>>> hw/rtl/positional_list_engine_unit.sv
// positional_list_engine_unit: top level of the positional list engine.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and ple_cell.

// Bounded ordered list of signed 32-bit words held in a row of DEPTH cells,
// one word per cell; requests are append, pop, read, insert and erase.
// Insert and erase move all later cells by one place at the same edge,
// each cell taking its neighbor's word. The result goes into an output
// register, so a new request is taken in the cycle after the last one and
// is held off only while a result waits for the sink. Entries are not
// cleared by reset; only the count and the result valid flag are.
module positional_list_engine_unit #(
  parameter int DEPTH = ple_pkg::DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [CW-1:0]                     cnt;
  logic [CW-1:0]                     cnt_next;
  logic [KW-1:0]                     pos_k;
  logic [KW-1:0]                     cnt_k;
  logic                              accept;
  logic                              in_range;
  logic                              full;
  logic                              empty;
  logic [ple_pkg::ST_W-1:0]          st;
  logic signed [ple_pkg::DATA_W-1:0] rd;
  logic signed [ple_pkg::DATA_W-1:0] sel_word;
  ple_pkg::cell_ctrl_t               ctrl_raw;
  ple_pkg::cell_ctrl_t               ctrl;

  logic signed [ple_pkg::DATA_W-1:0] q   [DEPTH];
  logic signed [ple_pkg::DATA_W-1:0] hit [DEPTH];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign pos_k     = KW'(req.position);
  assign cnt_k     = KW'(cnt);
  assign in_range  = pos_k < cnt_k;
  assign full      = cnt == CNT_FULL;
  assign empty     = cnt == '0;

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) sel_word = sel_word | hit[i];
  end

  always_comb begin
    st       = ple_pkg::ST_OK;
    rd       = '0;
    cnt_next = cnt;
    ctrl_raw = '0;
    case (req.opcode)
      ple_pkg::OP_APPEND: begin
        if (full) st = ple_pkg::ST_FULL;
        else begin
          ctrl_raw.app = 1'b1;
          cnt_next     = cnt + 1'b1;
        end
      end
      ple_pkg::OP_POP: begin
        if (empty) st = ple_pkg::ST_EMPTY;
        else cnt_next = cnt - 1'b1;
      end
      ple_pkg::OP_READ: begin
        if (!in_range) begin
          st = ple_pkg::ST_RANGE;
          rd = ple_pkg::READ_SENTINEL;
        end else rd = sel_word;
      end
      ple_pkg::OP_INSERT: begin
        if (!in_range) st = ple_pkg::ST_RANGE;
        else if (full) st = ple_pkg::ST_FULL;
        else begin
          ctrl_raw.ins = 1'b1;
          cnt_next     = cnt + 1'b1;
        end
      end
      ple_pkg::OP_ERASE: begin
        if (!in_range) st = ple_pkg::ST_RANGE;
        else begin
          ctrl_raw.era = 1'b1;
          cnt_next     = cnt - 1'b1;
        end
      end
      default: begin
        st = ple_pkg::ST_OK;
      end
    endcase
  end

  assign ctrl = accept ? ctrl_raw : '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_w;
    logic signed [ple_pkg::DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = q[g];
    end else begin : g_inner
      assign right_w = q[g+1];
    end
    ple_cell #(.IDX(g), .KW(KW)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (pos_k),
      .cnt   (cnt_k),
      .value (req.value),
      .left  (left_w),
      .right (right_w),
      .q     (q[g]),
      .hit   (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= rd;
      rsp.status     <= st;
      rsp.count      <= ple_pkg::CNT_OUT_W'(cnt_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("entry count above depth");

  a_rsp_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("no result after accepted transaction");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.count == ple_pkg::CNT_OUT_W'(cnt))
    else $error("result count differs from live count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ple_pkg::ST_EMPTY |-> cnt == '0)
    else $error("empty status with entries present");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ple_pkg::ST_FULL |-> cnt == CNT_FULL)
    else $error("full status with room left");

endmodule
